@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the tokenizer checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset qualification
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers reset cycles
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/stt_pkg.sv @@
package stt_pkg;

    localparam int WORD_MAX  = 32;
    localparam int LINE_BITS = 20;
    localparam int LEN_W     = $clog2(WORD_MAX + 2);
    localparam int IDX_W     = $clog2(WORD_MAX);
    localparam int KW_N      = 19;
    localparam int SLOTS     = 4;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int QDEPTH    = 2;
    localparam int Q_PTR_W   = $clog2(QDEPTH);
    localparam int Q_CNT_W   = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_LF = 8'd10;

    typedef enum logic [5:0] {
        TK_BEGIN = 6'd0, TK_NUMBER, TK_BOOL, TK_IF, TK_THEN, TK_ELSE, TK_END,
        TK_REPEAT, TK_UNTIL, TK_LOOP, TK_EXIT, TK_PUT, TK_GET, TK_VAR, TK_FUNC,
        TK_PROC, TK_BOOLEAN, TK_INTEGER, TK_SKIP, TK_RETURN, TK_IDENT, TK_STRING,
        TK_LBRACE, TK_RBRACE, TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK,
        TK_ASSIGN, TK_COLON, TK_SEMI, TK_EQ, TK_HASH, TK_LE, TK_LT, TK_GE, TK_GT,
        TK_NE, TK_PLUS, TK_MINUS, TK_BAR, TK_STAR, TK_SLASH, TK_AMP, TK_TILDE,
        TK_COMMA, TK_EOF, TK_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK, ST_UNKNOWN, ST_BANG, ST_UNTERM, ST_TRUNC
    } status_t;

    typedef enum logic [4:0] {
        M_IDLE   = 5'b00001,
        M_NUMBER = 5'b00010,
        M_WORD   = 5'b00100,
        M_STRING = 5'b01000,
        M_OPER   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic                 valid;
        logic                 run;
        logic [LEN_W-1:0]     run_len;
        kind_t                kind;
        logic [31:0]          value;
        logic [LINE_BITS-1:0] line;
        status_t              status;
        logic                 last;
    } slot_t;

    typedef slot_t [SLOTS-1:0] bundle_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_stat_t;

    localparam logic [55:0] KW_TEXT [KW_N] = '{
        "true", "false", "if", "then", "else", "end", "repeat", "until", "loop",
        "exit", "put", "get", "var", "func", "proc", "boolean", "integer",
        "skip", "return"
    };

    localparam logic [2:0] KW_LEN [KW_N] = '{
        3'd4, 3'd5, 3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3,
        3'd3, 3'd3, 3'd4, 3'd4, 3'd7, 3'd7, 3'd4, 3'd6
    };

    localparam kind_t KW_KIND [KW_N] = '{
        TK_BOOL, TK_BOOL, TK_IF, TK_THEN, TK_ELSE, TK_END, TK_REPEAT, TK_UNTIL,
        TK_LOOP, TK_EXIT, TK_PUT, TK_GET, TK_VAR, TK_FUNC, TK_PROC, TK_BOOLEAN,
        TK_INTEGER, TK_SKIP, TK_RETURN
    };

    localparam logic KW_VAL [KW_N] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };

    function automatic logic [7:0] kw_char(input int unsigned i, input logic [2:0] p);
        logic [2:0] sh;
        sh = KW_LEN[i] - 3'd1 - p;
        return KW_TEXT[i][{sh, 3'b000} +: 8];
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "[":     k = TK_LBRACK;
            "]":     k = TK_RBRACK;
            ";":     k = TK_SEMI;
            "=":     k = TK_EQ;
            "#":     k = TK_HASH;
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "|":     k = TK_BAR;
            "*":     k = TK_STAR;
            "/":     k = TK_SLASH;
            "&":     k = TK_AMP;
            "~":     k = TK_TILDE;
            ",":     k = TK_COMMA;
            default: k = TK_BEGIN;
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/stt_front.sv @@
module stt_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_source_byte,
    input  logic                        s_end_of_source,
    output logic                        push_valid,
    output stt_pkg::bundle_t            push_data,
    input  stt_pkg::q_stat_t            q_stat,
    input  logic                        run_done,
    input  logic [stt_pkg::IDX_W-1:0]   rd_idx,
    output logic [7:0]                  rd_data
);

    stt_pkg::mode_t                   mode_reg, mode_next;
    logic [31:0]                      acc_reg, acc_next;
    logic [stt_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [7:0]                       op_reg, op_next;
    logic [stt_pkg::KW_N-1:0]         match_reg, match_next;
    logic [stt_pkg::LINE_BITS-1:0]    line_reg, line_next;
    logic                             pend_reg;
    logic [7:0]                       word_mem [stt_pkg::WORD_MAX];

    logic                             accept;
    logic                             do_idle;
    logic                             wr_en;
    logic [stt_pkg::IDX_W-1:0]        wr_idx;
    logic                             any_valid;
    logic                             any_run;
    stt_pkg::kind_t                   pk;
    logic [7:0]                       b;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic stt_pkg::slot_t flush_slot(
        input stt_pkg::mode_t                mode,
        input logic [31:0]                   acc,
        input logic [stt_pkg::LEN_W-1:0]     len,
        input logic [7:0]                    op,
        input logic [stt_pkg::KW_N-1:0]      match,
        input logic [stt_pkg::LINE_BITS-1:0] line,
        input logic                          at_end
    );
        stt_pkg::slot_t s;
        logic           hit;
        s = '0;
        hit = 1'b0;
        s.line = line;
        s.kind = stt_pkg::TK_BEGIN;
        s.status = stt_pkg::ST_OK;
        unique case (mode)
            stt_pkg::M_NUMBER: begin
                s.valid = 1'b1;
                s.kind = stt_pkg::TK_NUMBER;
                s.value = acc;
            end
            stt_pkg::M_WORD: begin
                s.valid = 1'b1;
                if (len > stt_pkg::LEN_W'(stt_pkg::WORD_MAX)) begin
                    s.run = 1'b1;
                    s.run_len = stt_pkg::LEN_W'(stt_pkg::WORD_MAX);
                    s.kind = stt_pkg::TK_IDENT;
                    s.status = stt_pkg::ST_TRUNC;
                end else begin
                    for (int unsigned i = 0; i < stt_pkg::KW_N; i++) begin
                        if (match[i] && (len == stt_pkg::LEN_W'(stt_pkg::KW_LEN[i]))) begin
                            hit = 1'b1;
                            s.kind = stt_pkg::KW_KIND[i];
                            s.value = {31'd0, stt_pkg::KW_VAL[i]};
                        end
                    end
                    if (!hit) begin
                        s.run = 1'b1;
                        s.run_len = len;
                        s.kind = stt_pkg::TK_IDENT;
                    end
                end
            end
            stt_pkg::M_OPER: begin
                s.valid = 1'b1;
                case (op)
                    ":":     s.kind = stt_pkg::TK_COLON;
                    "<":     s.kind = stt_pkg::TK_LT;
                    ">":     s.kind = stt_pkg::TK_GT;
                    default: begin
                        s.kind = stt_pkg::TK_ERROR;
                        s.status = stt_pkg::ST_BANG;
                    end
                endcase
            end
            stt_pkg::M_STRING: begin
                if (at_end) begin
                    s.valid = 1'b1;
                    s.kind = stt_pkg::TK_ERROR;
                    s.status = stt_pkg::ST_UNTERM;
                end
            end
            default: begin
                s.valid = 1'b0;
            end
        endcase
        return s;
    endfunction

    assign b = s_source_byte;
    assign s_ready = !q_stat.full && !pend_reg;
    assign accept = s_valid && s_ready;
    assign rd_data = word_mem[rd_idx];

    always_comb begin
        mode_next = mode_reg;
        acc_next = acc_reg;
        len_next = len_reg;
        op_next = op_reg;
        match_next = match_reg;
        line_next = line_reg;
        wr_en = 1'b0;
        wr_idx = len_reg[stt_pkg::IDX_W-1:0];
        push_data = '0;
        do_idle = 1'b0;
        pk = stt_pkg::punct_kind(b);

        unique case (mode_reg)
            stt_pkg::M_NUMBER: begin
                if (is_digit(b)) begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + {24'd0, b - "0"};
                end else begin
                    push_data[0] = flush_slot(mode_reg, acc_reg, len_reg, op_reg,
                                              match_reg, line_reg, 1'b0);
                    do_idle = 1'b1;
                end
            end
            stt_pkg::M_WORD: begin
                if (is_alpha(b) || is_digit(b)) begin
                    if (len_reg < stt_pkg::LEN_W'(stt_pkg::WORD_MAX)) begin
                        wr_en = 1'b1;
                        len_next = len_reg + 1'b1;
                        for (int unsigned i = 0; i < stt_pkg::KW_N; i++) begin
                            match_next[i] = match_reg[i]
                                && (len_reg < stt_pkg::LEN_W'(stt_pkg::KW_LEN[i]))
                                && (stt_pkg::kw_char(i, len_reg[2:0]) == b);
                        end
                    end else begin
                        len_next = stt_pkg::LEN_W'(stt_pkg::WORD_MAX + 1);
                    end
                end else begin
                    push_data[0] = flush_slot(mode_reg, acc_reg, len_reg, op_reg,
                                              match_reg, line_reg, 1'b0);
                    do_idle = 1'b1;
                end
            end
            stt_pkg::M_STRING: begin
                push_data[1].valid = 1'b1;
                push_data[1].kind = stt_pkg::TK_STRING;
                push_data[1].line = line_reg;
                push_data[1].status = stt_pkg::ST_OK;
                if (b == "\"") begin
                    push_data[1].last = 1'b1;
                    mode_next = stt_pkg::M_IDLE;
                end else begin
                    push_data[1].value = {24'd0, b};
                end
            end
            stt_pkg::M_OPER: begin
                if (b == "=") begin
                    push_data[1].valid = 1'b1;
                    push_data[1].line = line_reg;
                    push_data[1].status = stt_pkg::ST_OK;
                    case (op_reg)
                        ":":     push_data[1].kind = stt_pkg::TK_ASSIGN;
                        "<":     push_data[1].kind = stt_pkg::TK_LE;
                        ">":     push_data[1].kind = stt_pkg::TK_GE;
                        default: push_data[1].kind = stt_pkg::TK_NE;
                    endcase
                    mode_next = stt_pkg::M_IDLE;
                    op_next = '0;
                end else begin
                    push_data[0] = flush_slot(mode_reg, acc_reg, len_reg, op_reg,
                                              match_reg, line_reg, 1'b0);
                    do_idle = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            mode_next = stt_pkg::M_IDLE;
            acc_next = '0;
            len_next = '0;
            op_next = '0;
            if (is_space(b)) begin
                if ((b == stt_pkg::CH_LF) && (line_reg != '1)) begin
                    line_next = line_reg + 1'b1;
                end
            end else if (is_digit(b)) begin
                mode_next = stt_pkg::M_NUMBER;
                acc_next = {24'd0, b - "0"};
            end else if (is_alpha(b)) begin
                mode_next = stt_pkg::M_WORD;
                wr_en = 1'b1;
                wr_idx = '0;
                len_next = stt_pkg::LEN_W'(1);
                for (int unsigned i = 0; i < stt_pkg::KW_N; i++) begin
                    match_next[i] = (stt_pkg::kw_char(i, 3'd0) == b);
                end
            end else if (b == "\"") begin
                mode_next = stt_pkg::M_STRING;
            end else if ((b == ":") || (b == "<") || (b == ">") || (b == "!")) begin
                mode_next = stt_pkg::M_OPER;
                op_next = b;
            end else begin
                push_data[1].valid = 1'b1;
                push_data[1].line = line_reg;
                if (pk != stt_pkg::TK_BEGIN) begin
                    push_data[1].kind = pk;
                    push_data[1].status = stt_pkg::ST_OK;
                end else begin
                    push_data[1].kind = stt_pkg::TK_ERROR;
                    push_data[1].value = {24'd0, b};
                    push_data[1].status = stt_pkg::ST_UNKNOWN;
                end
            end
        end

        if (s_end_of_source) begin
            push_data[2] = flush_slot(mode_next, acc_next, len_next, op_next,
                                      match_next, line_next, 1'b1);
            push_data[3].valid = 1'b1;
            push_data[3].kind = stt_pkg::TK_EOF;
            push_data[3].line = line_next;
            push_data[3].status = stt_pkg::ST_OK;
            mode_next = stt_pkg::M_IDLE;
            acc_next = '0;
            len_next = '0;
            op_next = '0;
            match_next = '0;
            line_next = stt_pkg::LINE_BITS'(1);
        end
    end

    always_comb begin
        any_valid = 1'b0;
        any_run = 1'b0;
        for (int unsigned k = 0; k < stt_pkg::SLOTS; k++) begin
            any_valid = any_valid | push_data[k].valid;
            any_run = any_run | (push_data[k].valid & push_data[k].run);
        end
    end

    assign push_valid = accept && any_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= stt_pkg::M_IDLE;
            acc_reg <= '0;
            len_reg <= '0;
            op_reg <= '0;
            match_reg <= '0;
            line_reg <= stt_pkg::LINE_BITS'(1);
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg <= acc_next;
            len_reg <= len_next;
            op_reg <= op_next;
            match_reg <= match_next;
            line_reg <= line_next;
        end
    end

    // hold input while the back end reads a buffered word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (push_valid && any_run) begin
            pend_reg <= 1'b1;
        end else if (run_done) begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            word_mem[wr_idx] <= b;
        end
    end

endmodule

@@ hw/rtl/stt_queue.sv @@
module stt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  stt_pkg::bundle_t push_data,
    input  logic             pop,
    output stt_pkg::q_stat_t q_stat,
    output stt_pkg::bundle_t head_data
);

    stt_pkg::bundle_t               mem_reg [stt_pkg::QDEPTH];
    logic [stt_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [stt_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [stt_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic                           do_pop;

    assign q_stat.full = (cnt_reg == stt_pkg::Q_CNT_W'(stt_pkg::QDEPTH));
    assign q_stat.head_valid = (cnt_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];
    assign do_pop = pop && q_stat.head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_valid && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push_valid && do_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/stt_back.sv @@
module stt_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  stt_pkg::q_stat_t                  q_stat,
    input  stt_pkg::bundle_t                  head_data,
    output logic                              pop,
    output logic                              run_done,
    output logic [stt_pkg::IDX_W-1:0]         rd_idx,
    input  logic [7:0]                        rd_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [5:0]                        m_token_kind,
    output logic [31:0]                       m_token_value,
    output logic [stt_pkg::LINE_BITS-1:0]     m_line_number,
    output logic [2:0]                        m_status,
    output logic                              m_last_of_run
);

    logic [stt_pkg::SLOT_W-1:0]     sidx_reg;
    logic [stt_pkg::IDX_W-1:0]      ridx_reg;
    logic                           m_valid_reg;
    logic [5:0]                     kind_reg;
    logic [31:0]                    value_reg;
    logic [stt_pkg::LINE_BITS-1:0]  line_reg;
    logic [2:0]                     status_reg;
    logic                           last_reg;

    logic [stt_pkg::SLOT_W-1:0]     j;
    logic                           more;
    stt_pkg::slot_t                 cur;
    logic                           emit;
    logic                           elem_last;

    always_comb begin
        j = stt_pkg::SLOT_W'(stt_pkg::SLOTS - 1);
        for (int k = stt_pkg::SLOTS - 1; k >= 0; k--) begin
            if ((stt_pkg::SLOT_W'(k) >= sidx_reg) && head_data[k].valid) begin
                j = stt_pkg::SLOT_W'(k);
            end
        end
        more = 1'b0;
        for (int k = 0; k < stt_pkg::SLOTS; k++) begin
            if ((stt_pkg::SLOT_W'(k) > j) && head_data[k].valid) begin
                more = 1'b1;
            end
        end
    end

    assign cur = head_data[j];
    assign emit = q_stat.head_valid && (!m_valid_reg || m_ready);
    assign elem_last = !cur.run
        || (ridx_reg == stt_pkg::IDX_W'(cur.run_len - 1'b1));
    assign run_done = emit && cur.run && elem_last;
    assign pop = emit && elem_last && !more;
    assign rd_idx = ridx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sidx_reg <= '0;
            ridx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
                if (!elem_last) begin
                    ridx_reg <= ridx_reg + 1'b1;
                end else begin
                    ridx_reg <= '0;
                    sidx_reg <= more ? j + 1'b1 : '0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= cur.kind;
            line_reg <= cur.line;
            status_reg <= cur.status;
            if (cur.run) begin
                value_reg <= {24'd0, rd_data};
                last_reg <= elem_last;
            end else begin
                value_reg <= cur.value;
                last_reg <= cur.last;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_token_kind = kind_reg;
    assign m_token_value = value_reg;
    assign m_line_number = line_reg;
    assign m_status = status_reg;
    assign m_last_of_run = last_reg;

endmodule

@@ hw/rtl/source_text_tokenizer_unit.sv @@
// Source text tokenizer.
// Input channel s_*: one source byte per word, s_end_of_source on the last
// byte of a program. Output channel m_*: one token result per word, with
// kind, value, line, status and a last_of_run flag on identifier and string
// character runs.
// Throughput: one byte per cycle. Each byte makes a bundle of up to four
// entries in a two-entry queue; the back end sends one result per cycle, so
// bytes that raise several results, or a stalled receiver, fill the queue
// and drop s_ready. An identifier that is not a keyword is sent from the word
// buffer as n results, and input holds until its last character has left
// the buffer.
// Results: a token's result is written to the queue when the byte that ends
// the token is accepted, and is then registered in the output register on m_*.
// Reset (aresetn low, synchronous): scanner idle, line counter 1, queue and
// output register empty. After end of source the scanner returns to the same
// state on its own. The output register holds its word while m_ready is low.
module source_text_tokenizer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_source_byte,
    input  logic                             s_end_of_source,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [5:0]                       m_token_kind,
    output logic [31:0]                      m_token_value,
    output logic [stt_pkg::LINE_BITS-1:0]    m_line_number,
    output logic [2:0]                       m_status,
    output logic                             m_last_of_run
);

    logic                           push_valid;
    stt_pkg::bundle_t               push_data;
    stt_pkg::bundle_t               head_data;
    stt_pkg::q_stat_t               q_stat;
    logic                           pop;
    logic                           run_done;
    logic [stt_pkg::IDX_W-1:0]      rd_idx;
    logic [7:0]                     rd_data;

    stt_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_byte   (s_source_byte),
        .s_end_of_source (s_end_of_source),
        .push_valid      (push_valid),
        .push_data       (push_data),
        .q_stat          (q_stat),
        .run_done        (run_done),
        .rd_idx          (rd_idx),
        .rd_data         (rd_data)
    );

    stt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (pop),
        .q_stat     (q_stat),
        .head_data  (head_data)
    );

    stt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .head_data     (head_data),
        .pop           (pop),
        .run_done      (run_done),
        .rd_idx        (rd_idx),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_token_value (m_token_value),
        .m_line_number (m_line_number),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

endmodule

@@ hw/rtl/stt_checker.sv @@
`include "assert_macros.svh"

module stt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [7:0]                       s_source_byte,
    input logic                             s_end_of_source,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [5:0]                       m_token_kind,
    input logic [31:0]                      m_token_value,
    input logic [stt_pkg::LINE_BITS-1:0]    m_line_number,
    input logic [2:0]                       m_status,
    input logic                             m_last_of_run
);

    `ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_token_value) && $stable(m_line_number), "output word changed while stalled")

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `ASSERT_RST(a_line_nonzero, aclk, aresetn, m_valid |-> m_line_number != '0, "line number zero")

    `ASSERT_RST(a_last_kind, aclk, aresetn, m_valid && m_last_of_run |-> m_token_kind == stt_pkg::TK_IDENT || m_token_kind == stt_pkg::TK_STRING, "last flag on single token")

    `ASSERT_RST(a_trunc_ident, aclk, aresetn, m_valid && m_status == stt_pkg::ST_TRUNC |-> m_token_kind == stt_pkg::TK_IDENT, "truncation status on non-identifier")

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);

@@ tb/tb_source_text_tokenizer_unit.sv @@
module tb_source_text_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
    } src_word_t;

    typedef struct packed {
        logic [5:0]                    kind;
        logic [31:0]                   value;
        logic [stt_pkg::LINE_BITS-1:0] line;
        logic [2:0]                    status;
        logic                          last;
    } token_t;

    localparam int LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_source_byte = 8'd0;
    logic s_end_of_source = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [5:0] m_token_kind;
    logic [31:0] m_token_value;
    logic [stt_pkg::LINE_BITS-1:0] m_line_number;
    logic [2:0] m_status;
    logic m_last_of_run;

    source_text_tokenizer_unit uut (.*);

    src_word_t src_q[$];
    token_t    token_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_tokens = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    bit stim_done = 0;

    // predictor state
    typedef enum logic [2:0] { SC_IDLE, SC_NUM, SC_WORD, SC_STR, SC_OPER } scan_t;
    scan_t      p_mode;
    logic [31:0] p_acc;
    logic [7:0] p_buf [stt_pkg::WORD_MAX];
    int         p_len;
    logic [stt_pkg::LINE_BITS-1:0] p_line;
    logic [7:0] p_op;

    string kw_names [stt_pkg::KW_N] = '{"true", "false", "if", "then", "else", "end",
        "repeat", "until", "loop", "exit", "put", "get", "var", "func", "proc", "boolean",
        "integer", "skip", "return"};
    stt_pkg::kind_t kw_kinds [stt_pkg::KW_N] = '{stt_pkg::TK_BOOL, stt_pkg::TK_BOOL,
        stt_pkg::TK_IF, stt_pkg::TK_THEN, stt_pkg::TK_ELSE, stt_pkg::TK_END,
        stt_pkg::TK_REPEAT, stt_pkg::TK_UNTIL, stt_pkg::TK_LOOP, stt_pkg::TK_EXIT,
        stt_pkg::TK_PUT, stt_pkg::TK_GET, stt_pkg::TK_VAR, stt_pkg::TK_FUNC,
        stt_pkg::TK_PROC, stt_pkg::TK_BOOLEAN, stt_pkg::TK_INTEGER, stt_pkg::TK_SKIP,
        stt_pkg::TK_RETURN};

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_let(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    task automatic push_token(stt_pkg::kind_t k, logic [31:0] v, stt_pkg::status_t st,
                              logic last);
        token_t t;
        t.kind = k;
        t.value = v;
        t.line = p_line;
        t.status = st;
        t.last = last;
        token_q.push_back(t);
    endtask

    task automatic clear_scan();
        p_mode = SC_IDLE;
        p_acc = 0;
        p_len = 0;
        p_op = 0;
    endtask

    task automatic tokens_of_word();
        int n;
        bit hit;
        string w;
        n = p_len;
        hit = 0;
        if (n > stt_pkg::WORD_MAX) begin
            for (int i = 0; i < stt_pkg::WORD_MAX; i++)
                push_token(stt_pkg::TK_IDENT, p_buf[i], stt_pkg::ST_TRUNC,
                           i == stt_pkg::WORD_MAX - 1);
        end else begin
            w = "";
            for (int i = 0; i < n; i++) w = {w, string'(p_buf[i])};
            for (int k = 0; k < stt_pkg::KW_N; k++) begin
                if (!hit && w == kw_names[k]) begin
                    hit = 1;
                    push_token(kw_kinds[k], k == 0 ? 32'd1 : 32'd0, stt_pkg::ST_OK, 1'b0);
                end
            end
            if (!hit)
                for (int i = 0; i < n; i++)
                    push_token(stt_pkg::TK_IDENT, p_buf[i], stt_pkg::ST_OK, i == n - 1);
        end
    endtask

    task automatic flush_token(bit at_end);
        case (p_mode)
            SC_NUM:  push_token(stt_pkg::TK_NUMBER, p_acc, stt_pkg::ST_OK, 1'b0);
            SC_WORD: tokens_of_word();
            SC_OPER: begin
                if (p_op == ":") push_token(stt_pkg::TK_COLON, 0, stt_pkg::ST_OK, 1'b0);
                else if (p_op == "<") push_token(stt_pkg::TK_LT, 0, stt_pkg::ST_OK, 1'b0);
                else if (p_op == ">") push_token(stt_pkg::TK_GT, 0, stt_pkg::ST_OK, 1'b0);
                else push_token(stt_pkg::TK_ERROR, 0, stt_pkg::ST_BANG, 1'b0);
            end
            SC_STR:  if (at_end) push_token(stt_pkg::TK_ERROR, 0, stt_pkg::ST_UNTERM, 1'b0);
            default: ;
        endcase
        clear_scan();
    endtask

    task automatic scan_fresh(logic [7:0] b);
        stt_pkg::kind_t k;
        p_mode = SC_IDLE;
        k = stt_pkg::TK_BEGIN;
        if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
            if (b == stt_pkg::CH_LF && p_line != '1) p_line = p_line + 1'b1;
        end else if (is_dig(b)) begin
            p_mode = SC_NUM;
            p_acc = b - "0";
        end else if (is_let(b)) begin
            p_mode = SC_WORD;
            p_buf[0] = b;
            p_len = 1;
        end else if (b == "\"") begin
            p_mode = SC_STR;
        end else if (b == ":" || b == "<" || b == ">" || b == "!") begin
            p_mode = SC_OPER;
            p_op = b;
        end else begin
            case (b)
                "{": k = stt_pkg::TK_LBRACE;
                "}": k = stt_pkg::TK_RBRACE;
                "(": k = stt_pkg::TK_LPAREN;
                ")": k = stt_pkg::TK_RPAREN;
                "[": k = stt_pkg::TK_LBRACK;
                "]": k = stt_pkg::TK_RBRACK;
                ";": k = stt_pkg::TK_SEMI;
                "=": k = stt_pkg::TK_EQ;
                "#": k = stt_pkg::TK_HASH;
                "+": k = stt_pkg::TK_PLUS;
                "-": k = stt_pkg::TK_MINUS;
                "|": k = stt_pkg::TK_BAR;
                "*": k = stt_pkg::TK_STAR;
                "/": k = stt_pkg::TK_SLASH;
                "&": k = stt_pkg::TK_AMP;
                "~": k = stt_pkg::TK_TILDE;
                ",": k = stt_pkg::TK_COMMA;
                default: k = stt_pkg::TK_BEGIN;
            endcase
            if (k != stt_pkg::TK_BEGIN) push_token(k, 0, stt_pkg::ST_OK, 1'b0);
            else push_token(stt_pkg::TK_ERROR, b, stt_pkg::ST_UNKNOWN, 1'b0);
        end
    endtask

    task automatic tokenize_byte(src_word_t w);
        logic [7:0] b;
        b = w.b;
        case (p_mode)
            SC_NUM: begin
                if (is_dig(b)) p_acc = p_acc * 32'd10 + (b - "0");
                else begin
                    flush_token(0);
                    scan_fresh(b);
                end
            end
            SC_WORD: begin
                if (is_let(b) || is_dig(b)) begin
                    if (p_len < stt_pkg::WORD_MAX) begin
                        p_buf[p_len] = b;
                        p_len++;
                    end else p_len = stt_pkg::WORD_MAX + 1;
                end else begin
                    flush_token(0);
                    scan_fresh(b);
                end
            end
            SC_STR: begin
                if (b == "\"") begin
                    push_token(stt_pkg::TK_STRING, 0, stt_pkg::ST_OK, 1'b1);
                    p_mode = SC_IDLE;
                end else push_token(stt_pkg::TK_STRING, b, stt_pkg::ST_OK, 1'b0);
            end
            SC_OPER: begin
                if (b == "=") begin
                    push_token(p_op == ":" ? stt_pkg::TK_ASSIGN :
                               p_op == "<" ? stt_pkg::TK_LE :
                               p_op == ">" ? stt_pkg::TK_GE : stt_pkg::TK_NE,
                               0, stt_pkg::ST_OK, 1'b0);
                    p_mode = SC_IDLE;
                    p_op = 0;
                end else begin
                    flush_token(0);
                    scan_fresh(b);
                end
            end
            default: scan_fresh(b);
        endcase
        if (w.eos) begin
            flush_token(1);
            push_token(stt_pkg::TK_EOF, 0, stt_pkg::ST_OK, 1'b0);
            clear_scan();
            p_line = 1;
        end
    endtask

    task automatic add_text(string s, bit eos_last);
        src_word_t w;
        for (int i = 0; i < s.len(); i++) begin
            w.b = s[i];
            w.eos = eos_last && (i == s.len() - 1);
            src_q.push_back(w);
        end
    endtask

    task automatic add_byte(logic [7:0] b, bit eos);
        src_word_t w;
        w.b = b;
        w.eos = eos;
        src_q.push_back(w);
    endtask

    function automatic string rand_word(int maxlen);
        string s;
        int n;
        n = $urandom_range(1, maxlen);
        s = string'(8'("a" + $urandom_range(0, 25)));
        for (int i = 1; i < n; i++) begin
            case ($urandom_range(0, 2))
                0: s = {s, string'(8'("a" + $urandom_range(0, 25)))};
                1: s = {s, string'(8'("A" + $urandom_range(0, 25)))};
                default: s = {s, string'(8'("0" + $urandom_range(0, 9)))};
            endcase
        end
        return s;
    endfunction

    initial begin
        forever #1 aclk = ~aclk;
    end

    // stimulus
    initial begin
        string pun;
        int pick;
        clear_scan();
        p_line = 1;
        for (int i = 0; i < stt_pkg::WORD_MAX; i++) p_buf[i] = 0;
        pun = "{}()[];=#+-|*/&~,:<>!";
        add_text("if x1:=4294967299;<=>=!=!a", 0);
        add_byte(8'd10, 0);
        add_text("true false\t\"s\n\"", 0);
        add_byte(8'hff, 0);
        add_byte(8'h80, 0);
        add_text("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghij", 0);
        add_text(" \"open", 1);
        add_text(">", 1);
        add_text("!", 1);
        add_text("return", 1);
        while (src_q.size() < 120) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1: add_text(kw_names[$urandom_range(0, stt_pkg::KW_N - 1)], 0);
                2, 3: add_text(rand_word(6), 0);
                4: add_text(rand_word(40), 0);
                5, 6: add_text($sformatf("%0d", $urandom), 0);
                7: add_text({"\"", rand_word(5), "\""}, 0);
                8, 9: add_byte(pun[$urandom_range(0, pun.len() - 1)], 0);
                10: add_text(":=", 0);
                11: add_byte(8'd10, 0);
                12: add_byte(8'($urandom_range(0, 255)), 0);
                13: add_byte(8'(" "), $urandom_range(0, 3) == 0);
                default: add_byte(8'(" "), 0);
            endcase
        end
        add_byte(8'(";"), 1);
    end

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == 3) aresetn <= 1'b1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tokenize_byte({s_source_byte, s_end_of_source});
                n_sent <= n_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || src_q.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                    if (src_q.size() == 0) stim_done <= 1;
                end else begin
                    src_word_t w;
                    w = src_q.pop_front();
                    s_valid <= 1'b1;
                    s_source_byte <= w.b;
                    s_end_of_source <= w.eos;
                    if ($urandom_range(0, 5) == 0)
                        send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20)
                                                               : $urandom_range(1, 2);
                end
            end
        end
    end

    // long receiver stall
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cycles == 60) hold_off <= 200;
            else if (hold_off > 0) hold_off <= hold_off - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                token_t exp_t;
                n_tokens <= n_tokens + 1;
                if (token_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected token kind %0d value %0h", $time,
                             m_token_kind, m_token_value);
                end else begin
                    exp_t = token_q.pop_front();
                    if (exp_t != {m_token_kind, m_token_value, m_line_number, m_status,
                                  m_last_of_run}) begin
                        errors++;
                        $display("%0t: expected k=%0d v=%0h l=%0d s=%0d e=%0b",
                                 $time, exp_t.kind, exp_t.value, exp_t.line, exp_t.status,
                                 exp_t.last);
                        $display("%0t: actual   k=%0d v=%0h l=%0d s=%0d e=%0b",
                                 $time, m_token_kind, m_token_value, m_line_number,
                                 m_status, m_last_of_run);
                    end
                end
            end
            if (cycles == 60 || hold_off > 0) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                                           : $urandom_range(1, 2);
            end
        end
    end

    initial begin
        wait ((stim_done && !s_valid) || cycles >= LIMIT);
        while (token_q.size() != 0 && cycles < LIMIT) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (cycles >= LIMIT) begin
            $display("simulation failed");
        end else begin
            $display("sent %0d source bytes, checked %0d tokens, %0d mismatches",
                     n_sent, n_tokens, errors);
            if (errors == 0 && token_q.size() == 0) $display("simulation ok");
            else $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/stt_pkg.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer_unit.sv
hw/rtl/stt_checker.sv
tb/tb_source_text_tokenizer_unit.sv
